>>> rtl/sus_pkg.sv
// types and constants shared by the sort unique set block
`timescale 1ns / 1ps

package sus_pkg;

  localparam int unsigned DataW = 32;

  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } sus_state_e;

  typedef struct packed {
    logic                    load;
    logic                    shift;
    logic signed [DataW-1:0] value;
  } sus_ctrl_t;

endpackage

>>> rtl/sort_unique_set_top.sv
// sort unique set: systolic insertion sorter that emits distinct values in order
// load state: one word taken per cycle, stored in the chain the same cycle unless full
// after the final word: the drain shifts out the stored values, duplicates yield no word
// first result is registered once the drain has shifted past each repeat of the smallest
// the chain stalls while a result waits in the output register to be taken
// reset empties the chain at once, no clearing pass
`timescale 1ns / 1ps

module sort_unique_set_top
  import sus_pkg::*;
#(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic signed [DataW-1:0] sample_value_i,
  input  logic                    final_item_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [DataW-1:0] unique_value_o,
  output logic                    final_result_o,
  output logic                    overflowed_o
);

  localparam int unsigned CntW = $clog2(MAX_ITEMS + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_ITEMS);

  sus_state_e state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic            overflow_q, overflow_d;
  logic            out_valid_q;
  logic signed [DataW-1:0] out_value_q;
  logic            out_final_q, out_ovf_q;

  logic in_acc, full, shift, emit, done;
  sus_ctrl_t ctrl;

  logic                    cell_valid [MAX_ITEMS];
  logic                    cell_gt    [MAX_ITEMS];
  logic signed [DataW-1:0] cell_value [MAX_ITEMS];

  assign full       = (count_q == CntMax);
  assign in_acc     = in_valid_i && in_ready_o;
  assign ctrl.load  = in_acc && !full;
  assign ctrl.shift = shift;
  assign ctrl.value = sample_value_i;

  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    logic                    lv, lg, rv;
    logic signed [DataW-1:0] lval, rval;
    if (i == 0) begin : g_first
      assign lv   = 1'b1;
      assign lg   = 1'b0;
      assign lval = '0;
    end else begin : g_mid
      assign lv   = cell_valid[i-1];
      assign lg   = cell_gt[i-1];
      assign lval = cell_value[i-1];
    end
    if (i == MAX_ITEMS - 1) begin : g_last
      assign rv   = 1'b0;
      assign rval = '0;
    end else begin : g_inner
      assign rv   = cell_valid[i+1];
      assign rval = cell_value[i+1];
    end
    sus_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .left_valid_i  (lv),
      .left_gt_i     (lg),
      .left_value_i  (lval),
      .right_valid_i (rv),
      .right_value_i (rval),
      .valid_o       (cell_valid[i]),
      .gt_o          (cell_gt[i]),
      .value_o       (cell_value[i])
    );
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_LOAD: begin
        if (in_acc && final_item_i) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (done) state_d = ST_LOAD;
      end
      default: state_d = ST_LOAD;
    endcase
  end

  // outputs of the control
  always_comb begin
    in_ready_o = 1'b0;
    shift      = 1'b0;
    case (state_q)
      ST_LOAD: begin
        in_ready_o = 1'b1;
      end
      ST_DRAIN: begin
        shift = !out_valid_q || out_ready_i;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  // skip a word whose successor holds the same value
  assign emit = shift && !(cell_valid[1] && (cell_value[1] == cell_value[0]));
  assign done = shift && !cell_valid[1];

  always_comb begin
    count_d    = count_q;
    overflow_d = overflow_q;
    if (done) begin
      count_d    = '0;
      overflow_d = 1'b0;
    end else if (in_acc) begin
      if (full) overflow_d = 1'b1;
      else      count_d    = count_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      count_q     <= '0;
      overflow_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      overflow_q <= overflow_d;
      if (emit)             out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_value_q <= cell_value[0];
      out_final_q <= !cell_valid[1];
      out_ovf_q   <= overflow_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign unique_value_o = out_value_q;
  assign final_result_o = out_final_q;
  assign overflowed_o   = out_ovf_q;

endmodule

>>> rtl/sus_cell.sv
// one cell of the insertion sort chain, holds one stored value
`timescale 1ns / 1ps

module sus_cell
  import sus_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  sus_ctrl_t               ctrl_i,
  input  logic                    left_valid_i,
  input  logic                    left_gt_i,
  input  logic signed [DataW-1:0] left_value_i,
  input  logic                    right_valid_i,
  input  logic signed [DataW-1:0] right_value_i,
  output logic                    valid_o,
  output logic                    gt_o,
  output logic signed [DataW-1:0] value_o
);

  logic                    valid_q, valid_d;
  logic signed [DataW-1:0] value_q, value_d;

  assign gt_o    = valid_q && (ctrl_i.value < value_q);
  assign valid_o = valid_q;
  assign value_o = value_q;

  always_comb begin
    valid_d = valid_q;
    value_d = value_q;
    if (ctrl_i.shift) begin
      valid_d = right_valid_i;
      value_d = right_value_i;
    end else if (ctrl_i.load) begin
      if (left_gt_i) begin
        valid_d = 1'b1;
        value_d = left_value_i;
      end else if (gt_o || (!valid_q && left_valid_i)) begin
        valid_d = 1'b1;
        value_d = ctrl_i.value;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

endmodule

>>> sim/tb_top.sv
// testbench for sort_unique_set_top: random sets in, distinct ascending words checked out
`timescale 1ns / 1ps

module tb_top
  import sus_pkg::*;
;

  localparam int unsigned SetCap = 64;
  localparam int unsigned TargetWords = 350;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned DrainCycles = SetCap + 36;

  typedef struct {
    logic signed [DataW-1:0] value;
    logic                    last;
    bit                      hold;
  } sample_word_t;

  typedef struct {
    logic signed [DataW-1:0] value;
    logic                    last;
    logic                    ovf;
  } unique_word_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic signed [DataW-1:0] sample_value = '0;
  logic                    final_item = 1'b0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic signed [DataW-1:0] unique_value;
  logic                    final_result;
  logic                    overflowed;
  logic                    in_took = 1'b0;

  sample_word_t            sample_q[$];
  unique_word_t            expected_uniques[$];
  logic signed [DataW-1:0] chain_vals[$];
  bit                      chain_ovf = 1'b0;

  int unsigned cycle_cnt = 0;
  int unsigned err_cnt = 0;
  int unsigned words_queued = 0;
  int unsigned words_in = 0;
  int unsigned words_out = 0;
  int unsigned sets_done = 0;
  int unsigned overflow_sets = 0;
  int          in_gap = 0;
  int          in_burst = 0;
  int          out_stall = 0;
  int          out_burst = 0;

  sort_unique_set_top #(
    .MAX_ITEMS(SetCap)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .sample_value_i(sample_value),
    .final_item_i  (final_item),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .unique_value_o(unique_value),
    .final_result_o(final_result),
    .overflowed_o  (overflowed)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  function automatic int pick_gap(inout int burst);
    int r;
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 49) == 0) begin
      burst = $urandom_range(20, 60);
    end
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [DataW-1:0] rand_sample(input int style);
    int r;
    r = $urandom_range(0, 9);
    if (style == 1 || (style == 2 && r >= 6 && r < 8)) begin
      return $urandom_range(0, 8) - 4;
    end else if (style == 2 && r >= 8) begin
      case ($urandom_range(0, 5))
        0: return 32'sh8000_0000;
        1: return 32'sh7fff_ffff;
        2: return 32'sh8000_0001;
        3: return 32'sh7fff_fffe;
        4: return -1;
        default: return 0;
      endcase
    end
    return $urandom;
  endfunction

  task automatic queue_word(input logic signed [DataW-1:0] v, input logic last, input bit hold);
    sample_q.push_back('{value: v, last: last, hold: hold});
    words_queued++;
  endtask

  task automatic queue_set(input int n, input bit hold_first);
    int style;
    style = $urandom_range(0, 2);
    for (int i = 0; i < n; i++) begin
      queue_word(rand_sample(style), i == n - 1, hold_first && i == 0);
    end
  endtask

  // insertion after equal values, drop once full, distinct run on the last word
  task automatic sort_and_emit(input logic signed [DataW-1:0] v, input logic last);
    int pos;
    unique_word_t w;
    if (chain_vals.size() < SetCap) begin
      pos = 0;
      while (pos < chain_vals.size() && chain_vals[pos] <= v) begin
        pos++;
      end
      chain_vals.insert(pos, v);
    end else begin
      chain_ovf = 1'b1;
    end
    if (last) begin
      for (int i = 0; i < chain_vals.size(); i++) begin
        if (i == 0 || chain_vals[i] != chain_vals[i-1]) begin
          w.value = chain_vals[i];
          w.last  = (chain_vals[i] == chain_vals[chain_vals.size()-1]);
          w.ovf   = chain_ovf;
          expected_uniques.push_back(w);
        end
      end
      sets_done++;
      if (chain_ovf) begin
        overflow_sets++;
      end
      chain_vals.delete();
      chain_ovf = 1'b0;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [DataW-1:0] got,
                                 input logic [DataW-1:0] want);
    err_cnt++;
    if (err_cnt <= 40) begin
      $display("%0t mismatch on %s: got %h want %h", $time, what, got, want);
    end
  endtask

  always @(negedge clk_i) begin
    sample_word_t w;
    logic nxt_valid;
    nxt_valid = in_valid;
    if (rst_ni) begin
      if (in_valid && !in_took) begin
        nxt_valid = 1'b1;
      end else if (in_gap > 0) begin
        nxt_valid = 1'b0;
        in_gap--;
      end else if (sample_q.size() > 0 &&
                   !(sample_q[0].hold && expected_uniques.size() > 0)) begin
        w = sample_q.pop_front();
        sample_value <= w.value;
        final_item   <= w.last;
        nxt_valid = 1'b1;
        in_gap = pick_gap(in_burst);
      end else begin
        nxt_valid = 1'b0;
      end
    end
    in_valid <= nxt_valid;
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else if (out_stall > 0) begin
      out_ready <= 1'b0;
      out_stall--;
    end else begin
      out_ready <= 1'b1;
      out_stall = pick_gap(out_burst);
    end
  end

  always @(posedge clk_i) begin
    unique_word_t e;
    if (rst_ni) begin
      if (out_valid && out_ready) begin
        if (expected_uniques.size() == 0) begin
          report_mismatch("unexpected word", unique_value, '0);
        end else begin
          e = expected_uniques.pop_front();
          words_out++;
          if (unique_value !== e.value) begin
            report_mismatch("unique_value", unique_value, e.value);
          end
          if (final_result !== e.last) begin
            report_mismatch("final_result", DataW'(final_result), DataW'(e.last));
          end
          if (overflowed !== e.ovf) begin
            report_mismatch("overflowed", DataW'(overflowed), DataW'(e.ovf));
          end
        end
      end
      if (in_valid && in_ready) begin
        words_in++;
        sort_and_emit(sample_value, final_item);
      end
    end
    in_took <= rst_ni && in_valid && in_ready;
  end

  initial begin
    int n;
    // single-word sets at both extremes
    queue_word(32'sh8000_0000, 1'b1, 1'b0);
    queue_word(32'sh7fff_ffff, 1'b1, 1'b0);
    // signed ordering across zero with a duplicate
    queue_word(32'sh7fff_ffff, 1'b0, 1'b1);
    queue_word(32'sh8000_0000, 1'b0, 1'b0);
    queue_word(0, 1'b0, 1'b0);
    queue_word(-1, 1'b0, 1'b0);
    queue_word(1, 1'b0, 1'b0);
    queue_word(-1, 1'b1, 1'b0);
    // all equal
    queue_word(5, 1'b0, 1'b0);
    queue_word(5, 1'b0, 1'b0);
    queue_word(5, 1'b1, 1'b0);
    // descending
    queue_word(3, 1'b0, 1'b0);
    queue_word(2, 1'b0, 1'b0);
    queue_word(1, 1'b0, 1'b0);
    queue_word(0, 1'b1, 1'b0);
    // repeated extremes
    queue_word(32'sh7fff_ffff, 1'b0, 1'b1);
    queue_word(32'sh8000_0000, 1'b0, 1'b0);
    queue_word(32'sh7fff_ffff, 1'b0, 1'b0);
    queue_word(32'sh8000_0000, 1'b1, 1'b0);
    // exactly full, then full with extras and the final word dropped
    queue_set(SetCap, 1'b1);
    queue_set(SetCap + 2, 1'b0);
    while (words_queued < TargetWords) begin
      if ($urandom_range(0, 11) == 0) begin
        n = $urandom_range(SetCap - 4, SetCap + 4);
      end else begin
        n = $urandom_range(1, 12);
      end
      queue_set(n, $urandom_range(0, 4) == 0);
    end

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (sample_q.size() != 0 || in_valid) begin
      @(posedge clk_i);
    end
    while (expected_uniques.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);

    $display("sent %0d words in %0d sets, %0d of them past capacity", words_in, sets_done,
             overflow_sets);
    $display("checked %0d distinct words, %0d mismatches", words_out, err_cnt);
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
    end
    $display("timeout after %0d cycles, %0d words still expected", cycle_cnt,
             expected_uniques.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

>>> files.f
rtl/sus_pkg.sv
rtl/sus_cell.sv
rtl/sort_unique_set_top.sv
sim/tb_top.sv
